[sv/pidp_pkg.sv]
// ============================================================================
// pidp_pkg - shared types and constants for the PID position loop step unit
// Holds register indexes, reset values, sequencer states, multiplier phases
// and the status bundle that the shared multiplier returns.
// ============================================================================
`default_nettype none

package pidp_pkg;

    // Width of the multiplier digit consumed per cycle
    localparam int CHUNK_BITS = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_STEP  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_STEP   = 3'd4;

    // Register reset values (truncated to the register width at use)
    localparam logic [63:0] GAIN_P_RESET    = 64'd6554;
    localparam logic [63:0] GAIN_I_RESET    = 64'd655;
    localparam logic [63:0] GAIN_D_RESET    = 64'd1311;
    localparam logic [63:0] TIME_STEP_RESET = 64'd655;
    localparam logic [63:0] INV_STEP_RESET  = 64'd6553600;

    // Tick sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_W_ESUM,
        ST_W_DERIV,
        ST_W_PTERM,
        ST_W_ITERM,
        ST_W_DTERM,
        ST_MOVE_GO,
        ST_W_MOVE,
        ST_OUT
    } seq_state_t;

    // Shared multiplier phases
    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FINISH
    } mul_phase_t;

    // Multiplier status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } mul_status_t;

endpackage

`default_nettype wire

[sv/pidp_satadd.sv]
// ============================================================================
// pidp_satadd - saturating add/subtract unit
// Adds or subtracts two signed words and clamps the result to the word range.
// ============================================================================
`default_nettype none

module pidp_satadd #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic                 subtract,
    output logic [WORD_BITS-1:0] sum,
    output logic                 sat
);

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS:0] ext_a;
    logic [WORD_BITS:0] ext_b;
    logic [WORD_BITS:0] wide;

    assign ext_a = {a[WORD_BITS-1], a};
    assign ext_b = {b[WORD_BITS-1], b};
    assign wide  = subtract ? (ext_a - ext_b) : (ext_a + ext_b);

    // Overflow when the guard bit and the sign bit disagree
    assign sat = wide[WORD_BITS] != wide[WORD_BITS-1];
    assign sum = sat ? (wide[WORD_BITS] ? WORD_MIN : WORD_MAX) : wide[WORD_BITS-1:0];

endmodule

`default_nettype wire

[sv/pidp_fxmul.sv]
// ============================================================================
// pidp_fxmul - shared iterative fixed-point multiplier
// Multiplies magnitudes one digit of the second operand per cycle, then
// shifts out the fraction, truncates toward zero and saturates.
// ============================================================================
`default_nettype none

module pidp_fxmul #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WORD_BITS-1:0]   op_a,
    input  logic [WORD_BITS-1:0]   op_b,
    output logic [WORD_BITS-1:0]   result,
    output pidp_pkg::mul_status_t  status
);

    localparam int CHUNK = pidp_pkg::CHUNK_BITS;
    localparam int STEPS = (WORD_BITS + CHUNK - 1) / CHUNK;
    localparam int PAD   = STEPS * CHUNK;
    localparam int ACC_W = 2 * WORD_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    pidp_pkg::mul_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic                 sat_reg, sat_next;

    logic [WORD_BITS-1:0] mag_a_reg, mag_a_next;
    logic [PAD-1:0]       mag_b_reg, mag_b_next;
    logic                 neg_reg, neg_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [WORD_BITS-1:0] result_reg, result_next;

    logic [WORD_BITS+CHUNK-1:0] step_prod;
    logic [ACC_W-1:0]           shifted;
    logic [ACC_W-1:0]           limit;
    logic                       over;

    assign step_prod = mag_a_reg * mag_b_reg[PAD-1 -: CHUNK];
    assign shifted   = acc_reg >> FRACTION_BITS;
    assign limit     = ACC_W'(WORD_MAX) + ACC_W'(neg_reg);
    assign over      = shifted > limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pidp_pkg::MUL_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        sat_next    = sat_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        result_next = result_reg;

        unique case (phase_reg)
            pidp_pkg::MUL_IDLE:
            begin
                if (start)
                begin
                    // Load magnitudes and the sign of the product
                    mag_a_next = op_a[WORD_BITS-1] ? (~op_a + 1'b1) : op_a;
                    mag_b_next = PAD'(op_b[WORD_BITS-1] ? (~op_b + 1'b1) : op_b);
                    neg_next   = op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
                    acc_next   = '0;
                    cnt_next   = CNT_W'(STEPS);
                    phase_next = pidp_pkg::MUL_RUN;
                end
            end
            pidp_pkg::MUL_RUN:
            begin
                // Top digit first: shift the partial sum up and add
                acc_next   = (acc_reg << CHUNK) + ACC_W'(step_prod);
                mag_b_next = mag_b_reg << CHUNK;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    phase_next = pidp_pkg::MUL_FINISH;
                end
            end
            pidp_pkg::MUL_FINISH:
            begin
                if (over)
                begin
                    result_next = neg_reg ? WORD_MIN : WORD_MAX;
                end
                else
                begin
                    result_next = neg_reg ? (~shifted[WORD_BITS-1:0] + 1'b1)
                                          : shifted[WORD_BITS-1:0];
                end
                sat_next   = over;
                done_next  = 1'b1;
                phase_next = pidp_pkg::MUL_IDLE;
            end
            default:
            begin
                phase_next = pidp_pkg::MUL_IDLE;
            end
        endcase
    end

    assign result      = result_reg;
    assign status.done = done_reg;
    assign status.sat  = sat_reg;

endmodule

`default_nettype wire

[sv/pid_position_loop_step_unit.sv]
// ============================================================================
// pid_position_loop_step_unit - discrete PID position loop, one tick per item
// Each input item is one control tick carrying a signed fixed-point target.
// The unit forms error = target - position, updates the error sum by
// error*dt, takes the derivative as (error - previous error) times the
// configured reciprocal of dt, forms drive = Kp*e + Ki*sum + Kd*deriv, then
// moves the position by drive*dt and keeps the error. Every product truncates
// toward zero after dropping FRACTION_BITS and every product or sum saturates
// to the word range; any clamp in the tick sets the clipped flag in tuser.
// All six products run through one shared multiplier that consumes a 16-bit
// digit per cycle; the unit takes one item at a time and drops tready while a
// tick is in flight. A finished result sits in an output register, so the
// next item is accepted while the result still waits. Configuration writes
// are always ready and take effect at once; write them only while the unit is idle.
// ============================================================================
`default_nettype none

module pid_position_loop_step_unit #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Target stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((WORD_BITS+7)/8)*8-1:0]         s_axis_tdata,  // target

    // Result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,  // position, drive
    output logic                                   m_axis_tuser,  // clipped

    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [WORD_BITS-1:0]                   cfg_data
);

    localparam int OUT_DATA_W = ((2 * WORD_BITS + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] gain_p_reg;
    logic [WORD_BITS-1:0] gain_i_reg;
    logic [WORD_BITS-1:0] gain_d_reg;
    logic [WORD_BITS-2:0] time_step_reg;
    logic [WORD_BITS-2:0] inv_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= WORD_BITS'(pidp_pkg::GAIN_P_RESET);
            gain_i_reg    <= WORD_BITS'(pidp_pkg::GAIN_I_RESET);
            gain_d_reg    <= WORD_BITS'(pidp_pkg::GAIN_D_RESET);
            time_step_reg <= (WORD_BITS-1)'(pidp_pkg::TIME_STEP_RESET);
            inv_step_reg  <= (WORD_BITS-1)'(pidp_pkg::INV_STEP_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pidp_pkg::CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                pidp_pkg::CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                pidp_pkg::CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                pidp_pkg::CFG_TIME_STEP: time_step_reg <= cfg_data[WORD_BITS-2:0];
                pidp_pkg::CFG_INV_STEP:  inv_step_reg  <= cfg_data[WORD_BITS-2:0];
                default:
                begin
                    // Drop writes to unknown indexes
                end
            endcase
        end
    end

    // Step and its reciprocal enter the multiplier as positive words
    logic [WORD_BITS-1:0] dt_word;
    logic [WORD_BITS-1:0] inv_word;

    assign dt_word  = {1'b0, time_step_reg};
    assign inv_word = {1'b0, inv_step_reg};

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    pidp_pkg::seq_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // Loop state
    logic [WORD_BITS-1:0] pos_reg, pos_next;
    logic [WORD_BITS-1:0] esum_reg, esum_next;
    logic [WORD_BITS-1:0] prev_reg, prev_next;

    // Per-tick working values
    logic [WORD_BITS-1:0] target_reg, target_next;
    logic [WORD_BITS-1:0] err_reg, err_next;
    logic [WORD_BITS-1:0] diff_reg, diff_next;
    logic [WORD_BITS-1:0] deriv_reg, deriv_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] drive_reg, drive_next;
    logic                 clip_reg, clip_next;

    // Output register
    logic [WORD_BITS-1:0] out_pos_reg, out_pos_next;
    logic [WORD_BITS-1:0] out_drive_reg, out_drive_next;
    logic                 out_clip_reg, out_clip_next;

    // Shared units
    logic [WORD_BITS-1:0]  alu_a;
    logic [WORD_BITS-1:0]  alu_b;
    logic                  alu_sub;
    logic [WORD_BITS-1:0]  alu_sum;
    logic                  alu_sat;

    logic                  mul_start;
    logic [WORD_BITS-1:0]  mul_a;
    logic [WORD_BITS-1:0]  mul_b;
    logic [WORD_BITS-1:0]  mul_result;
    pidp_pkg::mul_status_t mul_status;

    pidp_satadd #(
        .WORD_BITS (WORD_BITS)
    ) u_satadd (
        .a        (alu_a),
        .b        (alu_b),
        .subtract (alu_sub),
        .sum      (alu_sum),
        .sat      (alu_sat)
    );

    pidp_fxmul #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_fxmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_result),
        .status (mul_status)
    );

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            esum_reg      <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            esum_reg      <= esum_next;
            prev_reg      <= prev_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        err_reg       <= err_next;
        diff_reg      <= diff_next;
        deriv_reg     <= deriv_next;
        acc_reg       <= acc_next;
        drive_reg     <= drive_next;
        clip_reg      <= clip_next;
        out_pos_reg   <= out_pos_next;
        out_drive_reg <= out_drive_next;
        out_clip_reg  <= out_clip_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        esum_next      = esum_reg;
        prev_next      = prev_reg;
        target_next    = target_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        deriv_next     = deriv_reg;
        acc_next       = acc_reg;
        drive_next     = drive_reg;
        clip_next      = clip_reg;
        out_pos_next   = out_pos_reg;
        out_drive_next = out_drive_reg;
        out_clip_next  = out_clip_reg;

        alu_a     = acc_reg;
        alu_b     = mul_result;
        alu_sub   = 1'b0;
        mul_start = 1'b0;
        mul_a     = err_reg;
        mul_b     = dt_word;

        s_axis_tready = 1'b0;

        // Retire the waiting result
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pidp_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    target_next = s_axis_tdata[WORD_BITS-1:0];
                    clip_next   = 1'b0;
                    state_next  = pidp_pkg::ST_ERR;
                end
            end
            pidp_pkg::ST_ERR:
            begin
                // error = target - position
                alu_a      = target_reg;
                alu_b      = pos_reg;
                alu_sub    = 1'b1;
                err_next   = alu_sum;
                clip_next  = clip_reg | alu_sat;
                state_next = pidp_pkg::ST_DIFF;
            end
            pidp_pkg::ST_DIFF:
            begin
                // error change, and launch error*dt
                alu_a      = err_reg;
                alu_b      = prev_reg;
                alu_sub    = 1'b1;
                diff_next  = alu_sum;
                clip_next  = clip_reg | alu_sat;
                mul_start  = 1'b1;
                mul_a      = err_reg;
                mul_b      = dt_word;
                state_next = pidp_pkg::ST_W_ESUM;
            end
            pidp_pkg::ST_W_ESUM:
            begin
                if (mul_status.done)
                begin
                    alu_a      = esum_reg;
                    alu_b      = mul_result;
                    esum_next  = alu_sum;
                    clip_next  = clip_reg | alu_sat | mul_status.sat;
                    mul_start  = 1'b1;
                    mul_a      = diff_reg;
                    mul_b      = inv_word;
                    state_next = pidp_pkg::ST_W_DERIV;
                end
            end
            pidp_pkg::ST_W_DERIV:
            begin
                if (mul_status.done)
                begin
                    deriv_next = mul_result;
                    clip_next  = clip_reg | mul_status.sat;
                    mul_start  = 1'b1;
                    mul_a      = gain_p_reg;
                    mul_b      = err_reg;
                    state_next = pidp_pkg::ST_W_PTERM;
                end
            end
            pidp_pkg::ST_W_PTERM:
            begin
                if (mul_status.done)
                begin
                    acc_next   = mul_result;
                    clip_next  = clip_reg | mul_status.sat;
                    mul_start  = 1'b1;
                    mul_a      = gain_i_reg;
                    mul_b      = esum_reg;
                    state_next = pidp_pkg::ST_W_ITERM;
                end
            end
            pidp_pkg::ST_W_ITERM:
            begin
                if (mul_status.done)
                begin
                    alu_a      = acc_reg;
                    alu_b      = mul_result;
                    acc_next   = alu_sum;
                    clip_next  = clip_reg | alu_sat | mul_status.sat;
                    mul_start  = 1'b1;
                    mul_a      = gain_d_reg;
                    mul_b      = deriv_reg;
                    state_next = pidp_pkg::ST_W_DTERM;
                end
            end
            pidp_pkg::ST_W_DTERM:
            begin
                if (mul_status.done)
                begin
                    alu_a      = acc_reg;
                    alu_b      = mul_result;
                    drive_next = alu_sum;
                    clip_next  = clip_reg | alu_sat | mul_status.sat;
                    state_next = pidp_pkg::ST_MOVE_GO;
                end
            end
            pidp_pkg::ST_MOVE_GO:
            begin
                // Launch drive*dt
                mul_start  = 1'b1;
                mul_a      = drive_reg;
                mul_b      = dt_word;
                state_next = pidp_pkg::ST_W_MOVE;
            end
            pidp_pkg::ST_W_MOVE:
            begin
                if (mul_status.done)
                begin
                    alu_a      = pos_reg;
                    alu_b      = mul_result;
                    pos_next   = alu_sum;
                    prev_next  = err_reg;
                    clip_next  = clip_reg | alu_sat | mul_status.sat;
                    state_next = pidp_pkg::ST_OUT;
                end
            end
            pidp_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_pos_next   = pos_reg;
                    out_drive_next = drive_reg;
                    out_clip_next  = clip_reg;
                    out_valid_next = 1'b1;
                    state_next     = pidp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_drive_reg, out_pos_reg});
    assign m_axis_tuser  = out_clip_reg;

endmodule

`default_nettype wire
